// ===== hdl/tlsg_pkg.sv =====
// Package for the tile layer sprite generator: widths, register codes,
// reset values, FSM states and the request structs of the serial units.
// No dependencies.
package tlsg_pkg;

    localparam int DEF_MAX_MAP_SIDE = 256;

    localparam int TILE_W  = 16;
    localparam int POS_W   = 25;
    localparam int UV_W    = 17;
    localparam int CNT_W   = 5;
    localparam int DIV_W   = 17;
    localparam int STEP_W  = 15;
    localparam int ACC_W   = 31;
    localparam int PROD_W  = 26;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [TILE_W-1:0] EMPTY_TILE = 16'hFFFF;
    localparam logic [UV_W-1:0]   UV_SAT     = 17'd131071;
    localparam logic signed [ACC_W-1:0] POS_HI = 31'sd16777215;
    localparam logic signed [ACC_W-1:0] POS_LO = -31'sd16777215;

    localparam logic [CNT_W-1:0] DIVMOD_STEPS = 5'd16;
    localparam logic [CNT_W-1:0] CORNER_STEPS = 5'd17;
    localparam logic [CNT_W-1:0] MUL_STEPS    = 5'd16;

    localparam logic [8:0]  RST_ATLAS_COLUMNS = 9'd1;
    localparam logic [8:0]  RST_TILE_W        = 9'd16;
    localparam logic [8:0]  RST_TILE_H        = 9'd16;
    localparam logic [12:0] RST_SHEET_W       = 13'd256;
    localparam logic [12:0] RST_SHEET_H       = 13'd256;
    localparam logic [8:0]  RST_MAP_W         = 9'd16;
    localparam logic [8:0]  RST_MAP_H         = 9'd16;
    localparam logic [15:0] RST_CELL_SIZE     = 16'd256;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ATLAS_COLUMNS = 3'd0,
        CFG_TILE_W        = 3'd1,
        CFG_TILE_H        = 3'd2,
        CFG_SHEET_W       = 3'd3,
        CFG_SHEET_H       = 3'd4,
        CFG_MAP_W         = 3'd5,
        CFG_MAP_H         = 3'd6,
        CFG_CELL_SIZE     = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVMOD,
        S_MUL_A,
        S_START_A,
        S_WAIT_A,
        S_MUL_B,
        S_START_B,
        S_WAIT_B,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] dvd_bits;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                     start;
        logic signed [STEP_W-1:0] mcand;
        logic [15:0]              mplier;
    } t_mul_req;

endpackage

// ===== hdl/tlsg_if.sv =====
// Handshake interfaces of the tile layer sprite generator: tile input,
// sprite output and configuration write channel. Depends on tlsg_pkg.
interface tlsg_tile_if;
    logic                          valid;
    logic                          ready;
    logic [tlsg_pkg::TILE_W-1:0]   cell_tile;
    modport source (output valid, cell_tile, input ready);
    modport sink   (input valid, cell_tile, output ready);
endinterface

interface tlsg_sprite_if;
    logic                              valid;
    logic                              ready;
    logic signed [tlsg_pkg::POS_W-1:0] pos_x;
    logic signed [tlsg_pkg::POS_W-1:0] pos_y;
    logic [tlsg_pkg::UV_W-1:0]         uv_min_u;
    logic [tlsg_pkg::UV_W-1:0]         uv_min_v;
    logic [tlsg_pkg::UV_W-1:0]         uv_max_u;
    logic [tlsg_pkg::UV_W-1:0]         uv_max_v;
    modport source (output valid, pos_x, pos_y, uv_min_u, uv_min_v, uv_max_u, uv_max_v,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, uv_min_u, uv_min_v, uv_max_u, uv_max_v,
                    output ready);
endinterface

interface tlsg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tlsg_pkg::CFG_IW-1:0] index;
    logic [tlsg_pkg::CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tlsg_serdiv.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tlsg_pkg (t_div_req, widths).
module tlsg_serdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlsg_pkg::t_div_req           i_req,
    output logic                         o_busy,
    output logic [tlsg_pkg::DIV_W-1:0]   o_quo,
    output logic [tlsg_pkg::DIV_W-1:0]   o_rem
);
    logic [tlsg_pkg::CNT_W-1:0] r_cnt;
    logic [tlsg_pkg::DIV_W-1:0] r_rem;
    logic [tlsg_pkg::DIV_W-1:0] r_bits;
    logic [tlsg_pkg::DIV_W-1:0] r_div;
    logic [tlsg_pkg::DIV_W-1:0] r_quo;
    logic [tlsg_pkg::DIV_W+1:0] diff;
    logic                       qbit;

    assign diff = {1'b0, r_rem, r_bits[tlsg_pkg::DIV_W-1]} - {2'b00, r_div};
    assign qbit = ~diff[tlsg_pkg::DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_bits <= i_req.dvd_bits;
            r_div  <= i_req.divisor;
            r_quo  <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= qbit ? diff[tlsg_pkg::DIV_W-1:0]
                           : {r_rem[tlsg_pkg::DIV_W-2:0], r_bits[tlsg_pkg::DIV_W-1]};
            r_bits <= {r_bits[tlsg_pkg::DIV_W-2:0], 1'b0};
            r_quo  <= {r_quo[tlsg_pkg::DIV_W-2:0], qbit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ===== hdl/tlsg_sermul.sv =====
// Bit-serial signed-by-unsigned multiplier, multiplier MSB first, with
// saturation of the product to the 25-bit position range. Depends on tlsg_pkg.
module tlsg_sermul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlsg_pkg::t_mul_req                i_req,
    output logic                              o_busy,
    output logic signed [tlsg_pkg::POS_W-1:0] o_prod
);
    logic [tlsg_pkg::CNT_W-1:0]         r_cnt;
    logic signed [tlsg_pkg::ACC_W-1:0]  r_acc;
    logic signed [tlsg_pkg::STEP_W-1:0] r_mcand;
    logic [15:0]                        r_mplier;
    logic signed [tlsg_pkg::ACC_W-1:0]  addend;

    assign addend = r_mplier[15]
        ? {{(tlsg_pkg::ACC_W-tlsg_pkg::STEP_W){r_mcand[tlsg_pkg::STEP_W-1]}}, r_mcand}
        : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= tlsg_pkg::MUL_STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= i_req.mcand;
            r_mplier <= i_req.mplier;
        end else if (r_cnt != '0) begin
            r_acc    <= (r_acc <<< 1) + addend;
            r_mplier <= {r_mplier[14:0], 1'b0};
        end
    end

    always_comb begin
        if (r_acc > tlsg_pkg::POS_HI) begin
            o_prod = tlsg_pkg::POS_HI[tlsg_pkg::POS_W-1:0];
        end else if (r_acc < tlsg_pkg::POS_LO) begin
            o_prod = tlsg_pkg::POS_LO[tlsg_pkg::POS_W-1:0];
        end else begin
            o_prod = r_acc[tlsg_pkg::POS_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
endmodule

// ===== hdl/tile_layer_sprite_generator.sv =====
// Tile layer sprite generator top level: cell counters, configuration
// registers, sequencer and output register. Depends on tlsg_pkg, tlsg_if,
// tlsg_serdiv and tlsg_sermul.
//
//   port      dir   payload                                   done when
//   i_tile    in    cell_tile                                 valid & ready
//   o_sprite  out   pos_x pos_y uv_min_u/v uv_max_u/v         valid & ready
//   i_cfg     in    index (0..7), data                        valid & ready
//
// A cell is accepted in S_IDLE; an empty cell ends there. Any other cell
// runs a 16-step id divmod in S_DIVMOD, then two 17-step corner divisions
// (min, then max), each through a product, a start and a wait state, and
// S_OUT loads the output register. The two position multipliers run beside
// the divmod.
// i_rst_n is synchronous: counters clear, registers take their defaults.
// A result waits in the output register while the next cell is taken; the
// sequencer only stalls at its last step when that register is still full and o_sprite.ready is low.
module tile_layer_sprite_generator #(
    parameter int MAX_MAP_SIDE = tlsg_pkg::DEF_MAX_MAP_SIDE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlsg_tile_if.sink     i_tile,
    tlsg_cfg_if.sink      i_cfg,
    tlsg_sprite_if.source o_sprite
);
    localparam int CW = (MAX_MAP_SIDE > 1) ? $clog2(MAX_MAP_SIDE) : 1;

    // configuration
    logic [8:0]  r_atlas_columns;
    logic [8:0]  r_tile_w;
    logic [8:0]  r_tile_h;
    logic [12:0] r_sheet_w;
    logic [12:0] r_sheet_h;
    logic [8:0]  r_map_w;
    logic [8:0]  r_map_h;
    logic [15:0] r_cell_size;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;

    tlsg_pkg::t_state r_state;
    tlsg_pkg::t_state n_state;

    logic [tlsg_pkg::TILE_W-1:0] r_c;
    logic [tlsg_pkg::TILE_W-1:0] r_r;
    logic [tlsg_pkg::PROD_W-1:0] r_prod_u;
    logic [tlsg_pkg::PROD_W-1:0] r_prod_v;
    logic                        r_sat_u;
    logic                        r_sat_v;
    logic [tlsg_pkg::UV_W-1:0]   r_min_u;
    logic [tlsg_pkg::UV_W-1:0]   r_min_v;

    logic                              r_ov;
    logic signed [tlsg_pkg::POS_W-1:0] r_pos_x;
    logic signed [tlsg_pkg::POS_W-1:0] r_pos_y;
    logic [tlsg_pkg::UV_W-1:0]         r_uv_min_u;
    logic [tlsg_pkg::UV_W-1:0]         r_uv_min_v;
    logic [tlsg_pkg::UV_W-1:0]         r_uv_max_u;
    logic [tlsg_pkg::UV_W-1:0]         r_uv_max_v;

    logic [8:0]  w_eff;
    logic [8:0]  h_eff;
    logic [12:0] col_ext;
    logic [12:0] row_ext;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        col_wrap;
    logic        row_wrap;
    logic signed [tlsg_pkg::STEP_W-1:0] steps_x;
    logic signed [tlsg_pkg::STEP_W-1:0] steps_y;

    logic in_acc;
    logic is_empty;
    logic load_out;
    logic sat_u;
    logic sat_v;
    logic [tlsg_pkg::UV_W-1:0] idx_u;
    logic [tlsg_pkg::UV_W-1:0] idx_v;
    logic [tlsg_pkg::UV_W-1:0] max_u;
    logic [tlsg_pkg::UV_W-1:0] max_v;

    tlsg_pkg::t_div_req div_a_req;
    tlsg_pkg::t_div_req div_b_req;
    tlsg_pkg::t_mul_req mul_x_req;
    tlsg_pkg::t_mul_req mul_y_req;
    logic                              div_a_busy;
    logic                              div_b_busy;
    logic                              mul_x_busy;
    logic                              mul_y_busy;
    logic [tlsg_pkg::DIV_W-1:0]        div_a_quo;
    logic [tlsg_pkg::DIV_W-1:0]        div_a_rem;
    logic [tlsg_pkg::DIV_W-1:0]        div_b_quo;
    logic [tlsg_pkg::DIV_W-1:0]        div_b_rem;
    logic signed [tlsg_pkg::POS_W-1:0] mul_x_prod;
    logic signed [tlsg_pkg::POS_W-1:0] mul_y_prod;

    // configuration port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_columns <= tlsg_pkg::RST_ATLAS_COLUMNS;
            r_tile_w        <= tlsg_pkg::RST_TILE_W;
            r_tile_h        <= tlsg_pkg::RST_TILE_H;
            r_sheet_w       <= tlsg_pkg::RST_SHEET_W;
            r_sheet_h       <= tlsg_pkg::RST_SHEET_H;
            r_map_w         <= tlsg_pkg::RST_MAP_W;
            r_map_h         <= tlsg_pkg::RST_MAP_H;
            r_cell_size     <= tlsg_pkg::RST_CELL_SIZE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tlsg_pkg::CFG_ATLAS_COLUMNS: r_atlas_columns <= i_cfg.data[8:0];
                tlsg_pkg::CFG_TILE_W:        r_tile_w        <= i_cfg.data[8:0];
                tlsg_pkg::CFG_TILE_H:        r_tile_h        <= i_cfg.data[8:0];
                tlsg_pkg::CFG_SHEET_W:       r_sheet_w       <= i_cfg.data[12:0];
                tlsg_pkg::CFG_SHEET_H:       r_sheet_h       <= i_cfg.data[12:0];
                tlsg_pkg::CFG_MAP_W:         r_map_w         <= i_cfg.data[8:0];
                tlsg_pkg::CFG_MAP_H:         r_map_h         <= i_cfg.data[8:0];
                tlsg_pkg::CFG_CELL_SIZE:     r_cell_size     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // effective map sides: zero acts as one, clamp at MAX_MAP_SIDE
    always_comb begin
        if (r_map_w == '0) begin
            w_eff = 9'd1;
        end else if (32'(r_map_w) > MAX_MAP_SIDE) begin
            w_eff = 9'(MAX_MAP_SIDE);
        end else begin
            w_eff = r_map_w;
        end
        if (r_map_h == '0) begin
            h_eff = 9'd1;
        end else if (32'(r_map_h) > MAX_MAP_SIDE) begin
            h_eff = 9'(MAX_MAP_SIDE);
        end else begin
            h_eff = r_map_h;
        end
    end

    assign col_ext  = 13'(r_col);
    assign row_ext  = 13'(r_row);
    assign col_inc  = col_ext + 13'd1;
    assign row_inc  = row_ext + 13'd1;
    assign col_wrap = (col_inc >= {4'b0, w_eff});
    assign row_wrap = (row_inc >= {4'b0, h_eff});

    assign steps_x = $signed({1'b0, col_ext, 1'b1}) - $signed({6'b0, w_eff});
    assign steps_y = $signed({6'b0, h_eff}) - $signed({1'b0, row_ext, 1'b1});

    assign i_tile.ready = (r_state == tlsg_pkg::S_IDLE);
    assign in_acc       = i_tile.valid && i_tile.ready;
    assign is_empty     = (i_tile.cell_tile == tlsg_pkg::EMPTY_TILE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : CW'(row_inc);
            end else begin
                r_col <= CW'(col_inc);
            end
        end
    end

    // corner index: tile column / row, plus one for the max corner
    assign idx_u = (r_state == tlsg_pkg::S_MUL_B) ? {1'b0, r_c} + 17'd1 : {1'b0, r_c};
    assign idx_v = (r_state == tlsg_pkg::S_MUL_B) ? {1'b0, r_r} + 17'd1 : {1'b0, r_r};

    // quotient would pass 17 bits (or sheet is zero) exactly when prod >= 2*sheet
    assign sat_u = (r_prod_u >= {12'b0, r_sheet_w, 1'b0});
    assign sat_v = (r_prod_v >= {12'b0, r_sheet_h, 1'b0});

    assign max_u = r_sat_u ? tlsg_pkg::UV_SAT : div_a_quo;
    assign max_v = r_sat_v ? tlsg_pkg::UV_SAT : div_b_quo;

    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        div_a_req = '0;
        div_b_req = '0;
        mul_x_req = '0;
        mul_y_req = '0;

        mul_x_req.mcand  = steps_x;
        mul_x_req.mplier = r_cell_size;
        mul_y_req.mcand  = steps_y;
        mul_y_req.mplier = r_cell_size;

        case (r_state)
            tlsg_pkg::S_IDLE: begin
                div_a_req.steps    = tlsg_pkg::DIVMOD_STEPS;
                div_a_req.dvd_bits = {i_tile.cell_tile, 1'b0};
                div_a_req.divisor  = {8'b0, r_atlas_columns};
                if (in_acc && !is_empty) begin
                    div_a_req.start = 1'b1;
                    mul_x_req.start = 1'b1;
                    mul_y_req.start = 1'b1;
                    n_state         = tlsg_pkg::S_DIVMOD;
                end
            end
            tlsg_pkg::S_DIVMOD: begin
                if (!div_a_busy && !mul_x_busy && !mul_y_busy) begin
                    n_state = tlsg_pkg::S_MUL_A;
                end
            end
            tlsg_pkg::S_MUL_A: begin
                n_state = tlsg_pkg::S_START_A;
            end
            tlsg_pkg::S_START_A, tlsg_pkg::S_START_B: begin
                div_a_req.start    = 1'b1;
                div_a_req.steps    = tlsg_pkg::CORNER_STEPS;
                div_a_req.rem_init = r_prod_u[17:1];
                div_a_req.dvd_bits = {r_prod_u[0], 16'b0};
                div_a_req.divisor  = {4'b0, r_sheet_w};
                div_b_req.start    = 1'b1;
                div_b_req.steps    = tlsg_pkg::CORNER_STEPS;
                div_b_req.rem_init = r_prod_v[17:1];
                div_b_req.dvd_bits = {r_prod_v[0], 16'b0};
                div_b_req.divisor  = {4'b0, r_sheet_h};
                n_state = (r_state == tlsg_pkg::S_START_A) ? tlsg_pkg::S_WAIT_A
                                                           : tlsg_pkg::S_WAIT_B;
            end
            tlsg_pkg::S_WAIT_A: begin
                if (!div_a_busy && !div_b_busy) begin
                    n_state = tlsg_pkg::S_MUL_B;
                end
            end
            tlsg_pkg::S_MUL_B: begin
                n_state = tlsg_pkg::S_START_B;
            end
            tlsg_pkg::S_WAIT_B: begin
                if (!div_a_busy && !div_b_busy) begin
                    n_state = tlsg_pkg::S_OUT;
                end
            end
            tlsg_pkg::S_OUT: begin
                if (!r_ov || o_sprite.ready) begin
                    load_out = 1'b1;
                    n_state  = tlsg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlsg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tlsg_pkg::S_DIVMOD) begin
            r_c <= div_a_rem[tlsg_pkg::TILE_W-1:0];
            r_r <= div_a_quo[tlsg_pkg::TILE_W-1:0];
        end
        if (r_state == tlsg_pkg::S_MUL_A || r_state == tlsg_pkg::S_MUL_B) begin
            r_prod_u <= tlsg_pkg::PROD_W'(idx_u) * tlsg_pkg::PROD_W'(r_tile_w);
            r_prod_v <= tlsg_pkg::PROD_W'(idx_v) * tlsg_pkg::PROD_W'(r_tile_h);
        end
        if (r_state == tlsg_pkg::S_START_A || r_state == tlsg_pkg::S_START_B) begin
            r_sat_u <= sat_u;
            r_sat_v <= sat_v;
        end
        if (r_state == tlsg_pkg::S_WAIT_A && !div_a_busy && !div_b_busy) begin
            r_min_u <= max_u;
            r_min_v <= max_v;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_sprite.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pos_x    <= mul_x_prod;
            r_pos_y    <= mul_y_prod;
            r_uv_min_u <= r_min_u;
            r_uv_min_v <= r_min_v;
            r_uv_max_u <= max_u;
            r_uv_max_v <= max_v;
        end
    end

    assign o_sprite.valid    = r_ov;
    assign o_sprite.pos_x    = r_pos_x;
    assign o_sprite.pos_y    = r_pos_y;
    assign o_sprite.uv_min_u = r_uv_min_u;
    assign o_sprite.uv_min_v = r_uv_min_v;
    assign o_sprite.uv_max_u = r_uv_max_u;
    assign o_sprite.uv_max_v = r_uv_max_v;

    tlsg_serdiv u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_a_req),
        .o_busy  (div_a_busy),
        .o_quo   (div_a_quo),
        .o_rem   (div_a_rem)
    );

    tlsg_serdiv u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_b_req),
        .o_busy  (div_b_busy),
        .o_quo   (div_b_quo),
        .o_rem   (div_b_rem)
    );

    tlsg_sermul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_x_req),
        .o_busy  (mul_x_busy),
        .o_prod  (mul_x_prod)
    );

    tlsg_sermul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_y_req),
        .o_busy  (mul_y_busy),
        .o_prod  (mul_y_prod)
    );

    // divider B only runs corner divisions; its remainder is not needed
    logic unused_rem_b;
    assign unused_rem_b = ^div_b_rem;
endmodule
